### src/button_press_duration_classifier_unit_macros.svh
// Assertion macros for the button press duration classifier.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clock, quiet during reset.
`define BPDC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, quiet during reset.
`define BPDC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bpdc_pkg.sv
// Shared types and constants for the button press duration classifier.
// No dependencies; imported by bpdc_alu and the top level.
`default_nettype none

package bpdc_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int TIME_BITS   = 32;
   localparam int BTN_W       = $clog2(NUM_BUTTONS);
   localparam int CNT_W       = $clog2(NUM_BUTTONS + 1);
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int MASK_W      = 8;
   localparam int ACT_W       = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_HOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_HOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_MASK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_MASK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_MASK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE      = 3'd6;

   // Per-button class codes
   localparam logic [2:0] CLS_RELEASING = 3'd0;
   localparam logic [2:0] CLS_PRESSING  = 3'd1;
   localparam logic [2:0] CLS_PRESS     = 3'd2;
   localparam logic [2:0] CLS_SHORT     = 3'd3;
   localparam logic [2:0] CLS_LONG      = 3'd4;

   // Reported event codes
   localparam logic [1:0] EVT_PRESS = 2'd0;
   localparam logic [1:0] EVT_SHORT = 2'd1;
   localparam logic [1:0] EVT_LONG  = 2'd2;
   localparam logic [1:0] EVT_NONE  = 2'd3;

   // Reset values of the configuration registers
   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
   localparam logic [CFG_W-1:0] SHORT_RST    = 16'd1000;
   localparam logic [CFG_W-1:0] LONG_RST     = 16'd3000;

   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_GT  = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [TIME_BITS-1:0] a;
      logic [TIME_BITS-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic                 gt;
      logic [TIME_BITS-1:0] diff;
   } alu_res_type;

endpackage

`default_nettype wire

### src/bpdc_alu.sv
// Shared subtract/compare unit: one TIME_BITS-wide subtractor.
// Depends on bpdc_pkg for the request and result structs.
`default_nettype none

module bpdc_alu (
   input  bpdc_pkg::alu_req_type req,
   output bpdc_pkg::alu_res_type res
);
   import bpdc_pkg::*;

   logic [TIME_BITS-1:0] lhs;
   logic [TIME_BITS-1:0] rhs;
   logic [TIME_BITS:0]   wide;

   // Compare a > b as the borrow out of b - a.
   always_comb begin
      if (req.op == ALU_SUB) begin
         lhs = req.a;
         rhs = req.b;
      end else begin
         lhs = req.b;
         rhs = req.a;
      end
      wide     = {1'b0, lhs} - {1'b0, rhs};
      res.diff = wide[TIME_BITS-1:0];
      res.gt   = wide[TIME_BITS];
   end

endmodule

`default_nettype wire

### src/button_press_duration_classifier_unit.sv
// Button press duration classifier. An item is taken when start is high and busy is low;
// busy then stays high until the item is done. An edge item first forms the gap (an
// edge on a button not in use ends there), then makes up to three compares
// (debounce, long hold, short hold), all through the single shared subtractor in bpdc_alu.
// A scan item visits the N buttons in turn, N being the active button count capped at
// NUM_BUTTONS, then makes one end check and one flush. Reports leave on rsp_valid, at
// most one per cycle, each for a single cycle; the receiver cannot stall them. The last
// report of a scan is marked by rsp_last_of_scan.
`default_nettype none

module button_press_duration_classifier_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_kind,
   input  wire  [bpdc_pkg::BTN_W-1:0]       req_button_index,
   input  wire  [bpdc_pkg::TIME_BITS-1:0]   req_timestamp_ms,
   output logic                             rsp_valid,
   output logic [bpdc_pkg::BTN_W-1:0]       rsp_event_button,
   output logic [1:0]                       rsp_event_class,
   output logic                             rsp_last_of_scan,
   input  wire                              csr_we,
   input  wire  [bpdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [bpdc_pkg::CFG_W-1:0]       csr_wdata
);
   import bpdc_pkg::*;

   `include "button_press_duration_classifier_unit_macros.svh"

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_GAP   = 7'b0000010,
      S_DEB   = 7'b0000100,
      S_LONG  = 7'b0001000,
      S_SHORT = 7'b0010000,
      S_SCAN  = 7'b0100000,
      S_FLUSH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [CFG_W-1:0]  debounce_ff, short_ff, long_ff;
   logic [MASK_W-1:0] pmask_ff, smask_ff, lmask_ff;
   logic [ACT_W-1:0]  active_ff;

   // Per-button state
   logic [2:0]           cls_ff  [NUM_BUTTONS];
   logic [TIME_BITS-1:0] time_ff [NUM_BUTTONS];
   logic                 cls_we, time_we;
   logic [2:0]           cls_in;

   // Item latches
   logic [BTN_W-1:0]     idx_ff, idx_in;
   logic [TIME_BITS-1:0] ts_ff, ts_in;
   logic [TIME_BITS-1:0] gap_ff, gap_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;

   // Report held back until the next one or the end of the scan
   logic             pend_vld_ff, pend_vld_in;
   logic [BTN_W-1:0] pend_btn_ff, pend_btn_in;
   logic [1:0]       pend_cls_ff, pend_cls_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0] rsp_btn_ff, rsp_btn_in;
   logic [1:0]       rsp_cls_ff, rsp_cls_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0] eff_cnt;
   logic [BTN_W-1:0] rd_idx;
   logic [2:0]       rd_cls;
   logic [1:0]       evt_code;
   logic             evt_bit;
   logic             classified;

   alu_req_type alu_req;
   alu_res_type alu_res;

   bpdc_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   assign eff_cnt = (int'(active_ff) > NUM_BUTTONS) ? CNT_W'(NUM_BUTTONS) : CNT_W'(active_ff);
   assign rd_idx  = (state_ff == S_SCAN) ? scan_ff[BTN_W-1:0] : idx_ff;
   assign rd_cls  = cls_ff[rd_idx];

   always_comb begin
      classified = 1'b0;
      evt_code   = EVT_NONE;
      evt_bit    = 1'b0;
      case (rd_cls)
         CLS_PRESS: begin
            classified = 1'b1;
            evt_code   = EVT_PRESS;
            evt_bit    = pmask_ff[rd_idx];
         end
         CLS_SHORT: begin
            classified = 1'b1;
            evt_code   = EVT_SHORT;
            evt_bit    = smask_ff[rd_idx];
         end
         CLS_LONG: begin
            classified = 1'b1;
            evt_code   = EVT_LONG;
            evt_bit    = lmask_ff[rd_idx];
         end
         default: begin
            classified = 1'b0;
         end
      endcase
   end

   // Operand steering for the shared unit
   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = ts_ff;
      alu_req.b  = time_ff[idx_ff];
      unique case (state_ff)
         S_DEB: begin
            alu_req.op = ALU_GT;
            alu_req.a  = gap_ff;
            alu_req.b  = TIME_BITS'(debounce_ff);
         end
         S_LONG: begin
            alu_req.op = ALU_GT;
            alu_req.a  = gap_ff;
            alu_req.b  = TIME_BITS'(long_ff);
         end
         S_SHORT: begin
            alu_req.op = ALU_GT;
            alu_req.a  = gap_ff;
            alu_req.b  = TIME_BITS'(short_ff);
         end
         default: begin
            alu_req.op = ALU_SUB;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ts_in       = ts_ff;
      gap_in      = gap_ff;
      scan_in     = scan_ff;
      pend_vld_in = pend_vld_ff;
      pend_btn_in = pend_btn_ff;
      pend_cls_in = pend_cls_ff;
      rsp_valid_in = 1'b0;
      rsp_btn_in   = rsp_btn_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_last_in  = 1'b0;
      cls_we  = 1'b0;
      cls_in  = CLS_RELEASING;
      time_we = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in  = req_button_index;
               ts_in   = req_timestamp_ms;
               scan_in = '0;
               state_in = req_kind ? S_SCAN : S_GAP;
            end
         end
         S_GAP: begin
            // Drop edges on buttons that are not in use.
            if ({1'b0, idx_ff} < eff_cnt) begin
               gap_in   = alu_res.diff;
               time_we  = 1'b1;
               state_in = S_DEB;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DEB: begin
            state_in = S_IDLE;
            if (alu_res.gt) begin
               if (rd_cls == CLS_RELEASING) begin
                  cls_we = 1'b1;
                  cls_in = CLS_PRESSING;
               end else if (rd_cls == CLS_PRESSING) begin
                  state_in = S_LONG;
               end
            end
         end
         S_LONG: begin
            if (alu_res.gt) begin
               cls_we   = 1'b1;
               cls_in   = CLS_LONG;
               state_in = S_IDLE;
            end else begin
               state_in = S_SHORT;
            end
         end
         S_SHORT: begin
            cls_we   = 1'b1;
            cls_in   = alu_res.gt ? CLS_SHORT : CLS_PRESS;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (scan_ff < eff_cnt) begin
               if (classified) begin
                  cls_we = 1'b1;
                  cls_in = CLS_RELEASING;
                  if (evt_bit) begin
                     // Release the held report; it is not the last one.
                     rsp_valid_in = pend_vld_ff;
                     rsp_btn_in   = pend_btn_ff;
                     rsp_cls_in   = pend_cls_ff;
                     pend_vld_in  = 1'b1;
                     pend_btn_in  = rd_idx;
                     pend_cls_in  = evt_code;
                  end
               end
               scan_in = scan_ff + 1'b1;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            rsp_valid_in = pend_vld_ff;
            rsp_btn_in   = pend_btn_ff;
            rsp_cls_in   = pend_cls_ff;
            rsp_last_in  = 1'b1;
            pend_vld_in  = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         debounce_ff  <= DEBOUNCE_RST;
         short_ff     <= SHORT_RST;
         long_ff      <= LONG_RST;
         pmask_ff     <= '0;
         smask_ff     <= '0;
         lmask_ff     <= '0;
         active_ff    <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            cls_ff[i]  <= CLS_RELEASING;
            time_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cls_we) begin
            cls_ff[rd_idx] <= cls_in;
         end
         if (time_we) begin
            time_ff[idx_ff] <= ts_ff;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_DEBOUNCE:   debounce_ff <= csr_wdata;
               REG_SHORT_HOLD: short_ff    <= csr_wdata;
               REG_LONG_HOLD:  long_ff     <= csr_wdata;
               REG_PRESS_MASK: pmask_ff    <= csr_wdata[MASK_W-1:0];
               REG_SHORT_MASK: smask_ff    <= csr_wdata[MASK_W-1:0];
               REG_LONG_MASK:  lmask_ff    <= csr_wdata[MASK_W-1:0];
               REG_ACTIVE:     active_ff   <= csr_wdata[ACT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ts_ff       <= ts_in;
      gap_ff      <= gap_in;
      scan_ff     <= scan_in;
      pend_btn_ff <= pend_btn_in;
      pend_cls_ff <= pend_cls_in;
      rsp_btn_ff  <= rsp_btn_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = rsp_btn_ff;
   assign rsp_event_class  = rsp_cls_ff;
   assign rsp_last_of_scan = rsp_last_ff;

   `BPDC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `BPDC_ASSERT_IMP(a_mid_scan_busy, rsp_valid && !rsp_last_of_scan, busy,
                    "non-final report after scan ended")
   `BPDC_ASSERT_IMP(a_idle_no_pending, state_ff == S_IDLE, !pend_vld_ff,
                    "report left pending after scan")
   `BPDC_ASSERT_IMP(a_valid_code, rsp_valid, rsp_event_class != EVT_NONE,
                    "report carries no event class")

endmodule

`default_nettype wire
